FILE: sv/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// shared types, constants and helpers of the tournament fusion predictor
// ----------------------------------------------------------------------------
`default_nettype none

package tfp_pkg;

  // fixed field widths
  localparam int PC_W   = 64;
  localparam int TAG_W  = 8;
  localparam int DIST_W = 8;
  localparam int CTR_W  = 2;

  // parameter defaults
  localparam int SETS_DEF             = 256;
  localparam int WAYS_DEF             = 4;
  localparam int SELECTOR_ENTRIES_DEF = 2048;

  // operation codes
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // counter values
  localparam logic [CTR_W-1:0] CTR_ZERO       = 2'd0;
  localparam logic [CTR_W-1:0] CTR_ONE        = 2'd1;
  localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;
  localparam logic [CTR_W-1:0] CHOOSER_GLOBAL = 2'd2;

  // one way of a set
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [DIST_W-1:0] distance;
    logic [CTR_W-1:0]  ctr;
    logic              used;
  } way_t;

  // lookup outcome of one set
  typedef struct packed {
    logic              hit;
    logic              fuse;
    logic [DIST_W-1:0] distance;
  } lookup_t;

  function automatic int addr_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // saturating 2-bit counter step
  function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] c, input logic up);
    logic [CTR_W-1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + CTR_ONE;
    end else begin
      if (c != CTR_ZERO) r = c - CTR_ONE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/tfp_ram.sv
// ----------------------------------------------------------------------------
// tfp_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = tfp_pkg::addr_w(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/tfp_mod_unit.sv
// ----------------------------------------------------------------------------
// tfp_mod_unit
// remainder of a 64-bit value by a constant, a mask for powers of two,
// otherwise one 4-bit digit per cycle with restoring compare and subtract
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_mod_unit #(
  parameter int MOD = 256,
  localparam int RW = tfp_pkg::addr_w(MOD)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [tfp_pkg::PC_W-1:0]  value,
  output logic                           done,
  output logic      [RW-1:0]             rem
);

  localparam bit IS_POW2 = (MOD & (MOD - 1)) == 0;

  logic          done_q;
  logic [RW-1:0] rem_q;

  generate
    if (IS_POW2) begin : g_pow2
      always_ff @(posedge clk) begin
        if (rst) begin
          done_q <= 1'b0;
        end else if (start) begin
          done_q <= 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem_q <= RW'(value & tfp_pkg::PC_W'(MOD - 1));
        end
      end
    end else begin : g_iter
      localparam int DIGIT_W = 4;
      localparam int STEPS   = tfp_pkg::PC_W / DIGIT_W;
      localparam int CNT_W   = $clog2(STEPS + 1);
      localparam int TW      = RW + DIGIT_W;

      logic [tfp_pkg::PC_W-1:0] shreg;
      logic [CNT_W-1:0]         cnt;
      logic [TW-1:0]            x;

      // bring {rem, digit} back below MOD
      always_comb begin
        x = {rem_q, shreg[tfp_pkg::PC_W-1 -: DIGIT_W]};
        for (int s = DIGIT_W - 1; s >= 0; s--) begin
          if (x >= (TW'(MOD) << s)) begin
            x = x - (TW'(MOD) << s);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          done_q <= 1'b0;
          cnt    <= '0;
        end else if (start) begin
          done_q <= 1'b0;
          cnt    <= CNT_W'(STEPS);
        end else if (cnt != '0) begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            done_q <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          shreg <= value;
          rem_q <= '0;
        end else if (cnt != '0) begin
          shreg <= shreg << DIGIT_W;
          rem_q <= x[RW-1:0];
        end
      end
    end
  endgenerate

  assign done = done_q;
  assign rem  = rem_q;

endmodule

`default_nettype wire

FILE: sv/tfp_set_logic.sv
// ----------------------------------------------------------------------------
// tfp_set_logic
// tag match over one set, prediction and the trained row for an update
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_set_logic #(
  parameter int WAYS = 4
) (
  input  wire tfp_pkg::way_t [WAYS-1:0]     row,
  input  wire logic [tfp_pkg::TAG_W-1:0]    tag,
  input  wire logic [tfp_pkg::DIST_W-1:0]   fuse_dist,
  input  wire logic                         correct,
  output tfp_pkg::lookup_t                  result,
  output tfp_pkg::way_t [WAYS-1:0]          row_next
);

  localparam int WW = tfp_pkg::addr_w(WAYS);

  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] free_vec;
  logic [WW-1:0]   hit_way;
  logic [WW-1:0]   free_way;

  // lowest matching way and lowest way with a clear use bit
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = (row[w].tag == tag);
      free_vec[w] = !row[w].used;
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w])  hit_way  = WW'(w);
      if (free_vec[w]) free_way = WW'(w);
    end
  end

  always_comb begin
    result.hit      = |hit_vec;
    result.fuse     = (|hit_vec) && (row[hit_way].ctr == tfp_pkg::CTR_MAX);
    result.distance = (|hit_vec) ? row[hit_way].distance : '0;
  end

  always_comb begin
    row_next = row;
    if (|hit_vec) begin
      if (row[hit_way].distance == fuse_dist) begin
        row_next[hit_way].ctr = tfp_pkg::ctr_step(row[hit_way].ctr, correct);
      end else begin
        row_next[hit_way].distance = fuse_dist;
        row_next[hit_way].ctr      = tfp_pkg::CTR_ONE;
      end
      row_next[hit_way].used = 1'b1;
    end else begin
      // all ways in use: age the whole set and refill way 0
      if (!(|free_vec)) begin
        for (int w = 0; w < WAYS; w++) begin
          row_next[w].used = 1'b0;
        end
      end
      row_next[free_way].tag      = tag;
      row_next[free_way].distance = fuse_dist;
      row_next[free_way].ctr      = correct ? tfp_pkg::CTR_MAX : tfp_pkg::CTR_ONE;
      row_next[free_way].used     = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tournament_fusion_predictor.sv
// ----------------------------------------------------------------------------
// tournament_fusion_predictor
// fusion predictor with local and global set-associative tables and a chooser
// ----------------------------------------------------------------------------
// The block takes one word at a time on the request channel: a predict word
// returns one response word (hit, fuse_predicted, predicted_distance), an
// update word trains the tables and returns nothing. After reset a clearing
// pass over max(SETS, SELECTOR_ENTRIES) addresses (2048 at the defaults)
// zeroes all three tables before the first request is taken. A word passes
// the accepting idle state, a calc state that waits for the table indexes and
// reads the memories, and an exec state that evaluates and writes back. With
// SETS and SELECTOR_ENTRIES powers of two the indexes are masks ready in calc;
// other sizes hold calc until the nibble-serial modulo units are done.
// A predict word also waits while the response register still holds an
// untaken word; a new request is accepted regardless of the response side.
// ----------------------------------------------------------------------------
`default_nettype none

module tournament_fusion_predictor #(
  parameter int SETS             = tfp_pkg::SETS_DEF,
  parameter int WAYS             = tfp_pkg::WAYS_DEF,
  parameter int SELECTOR_ENTRIES = tfp_pkg::SELECTOR_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // request channel
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire logic                         op,
  input  wire logic [tfp_pkg::PC_W-1:0]     pc,
  input  wire logic [tfp_pkg::PC_W-1:0]     history,
  input  wire logic [tfp_pkg::DIST_W-1:0]   fuse_distance,
  input  wire logic                         was_correct,
  // response channel
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output logic                              hit,
  output logic                              fuse_predicted,
  output logic      [tfp_pkg::DIST_W-1:0]   predicted_distance
);

  localparam int SET_AW = tfp_pkg::addr_w(SETS);
  localparam int SEL_AW = tfp_pkg::addr_w(SELECTOR_ENTRIES);
  localparam int ROW_W  = WAYS * $bits(tfp_pkg::way_t);
  localparam int CLR_N  = (SETS > SELECTOR_ENTRIES) ? SETS : SELECTOR_ENTRIES;
  localparam int CLR_W  = tfp_pkg::addr_w(CLR_N);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CALC  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_t;

  state_t state, state_next;

  // clearing pass counter
  logic [CLR_W-1:0] clr_cnt;
  logic             clr_last;

  // captured request word
  logic                        op_q;
  logic [tfp_pkg::TAG_W-1:0]   tag_q;
  logic [tfp_pkg::DIST_W-1:0]  dist_q;
  logic                        correct_q;

  logic start;
  logic all_done;
  logic exec_fire;
  logic rd_en;

  // index units
  logic              loc_done, glb_done, sel_done;
  logic [SET_AW-1:0] loc_idx, glb_idx;
  logic [SEL_AW-1:0] sel_idx;

  // memory ports
  logic [ROW_W-1:0]          loc_rd, glb_rd;
  logic                      loc_wr_en, glb_wr_en, sel_wr_en;
  logic [SET_AW-1:0]         loc_wr_addr, glb_wr_addr;
  logic [SEL_AW-1:0]         sel_wr_addr;
  logic [ROW_W-1:0]          loc_wr_data, glb_wr_data;
  logic [tfp_pkg::CTR_W-1:0] sel_rd, sel_wr_data;

  // evaluation
  logic [tfp_pkg::CTR_W-1:0]  chooser_next;
  logic                       use_global;
  logic [ROW_W-1:0]           row_sel;
  tfp_pkg::lookup_t           result;
  tfp_pkg::way_t [WAYS-1:0]   row_new;

  assign start     = req_valid && req_ready;
  assign req_ready = (state == ST_IDLE);
  assign all_done  = loc_done && glb_done && sel_done;
  assign rd_en     = (state == ST_CALC) && all_done;
  assign clr_last  = (clr_cnt == CLR_W'(CLR_N - 1));

  // an update never waits, a predict waits for room in the response register
  assign exec_fire = (state == ST_EXEC) &&
                     ((op_q == tfp_pkg::OP_UPDATE) || !rsp_valid || rsp_ready);

  // ---------------- control ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last)  state_next = ST_IDLE;
      ST_IDLE:  if (start)     state_next = ST_CALC;
      ST_CALC:  if (all_done)  state_next = ST_EXEC;
      ST_EXEC:  if (exec_fire) state_next = ST_IDLE;
      default:                 state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
    end
  end

  // request capture, the index units keep pc and history themselves
  always_ff @(posedge clk) begin
    if (start) begin
      op_q      <= op;
      tag_q     <= pc[tfp_pkg::TAG_W-1:0];
      dist_q    <= fuse_distance;
      correct_q <= was_correct;
    end
  end

  // ---------------- index units ----------------
  tfp_mod_unit #(.MOD(SETS)) u_mod_loc (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (pc),
    .done  (loc_done),
    .rem   (loc_idx)
  );

  tfp_mod_unit #(.MOD(SETS)) u_mod_glb (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (pc ^ history),
    .done  (glb_done),
    .rem   (glb_idx)
  );

  tfp_mod_unit #(.MOD(SELECTOR_ENTRIES)) u_mod_sel (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (pc),
    .done  (sel_done),
    .rem   (sel_idx)
  );

  // ---------------- evaluation ----------------
  // an update steps the chooser first and trains the table the new value picks
  assign chooser_next = tfp_pkg::ctr_step(sel_rd, correct_q);
  assign use_global   = ((op_q == tfp_pkg::OP_UPDATE) ? chooser_next : sel_rd)
                        >= tfp_pkg::CHOOSER_GLOBAL;
  assign row_sel      = use_global ? glb_rd : loc_rd;

  tfp_set_logic #(.WAYS(WAYS)) u_set (
    .row       (row_sel),
    .tag       (tag_q),
    .fuse_dist (dist_q),
    .correct   (correct_q),
    .result    (result),
    .row_next  (row_new)
  );

  // write ports: clearing pass or write-back of an update
  always_comb begin
    loc_wr_en   = 1'b0;
    glb_wr_en   = 1'b0;
    sel_wr_en   = 1'b0;
    loc_wr_addr = loc_idx;
    glb_wr_addr = glb_idx;
    sel_wr_addr = sel_idx;
    loc_wr_data = row_new;
    glb_wr_data = row_new;
    sel_wr_data = chooser_next;
    if (state == ST_CLEAR) begin
      loc_wr_en   = (32'(clr_cnt) < SETS);
      glb_wr_en   = (32'(clr_cnt) < SETS);
      sel_wr_en   = (32'(clr_cnt) < SELECTOR_ENTRIES);
      loc_wr_addr = clr_cnt[SET_AW-1:0];
      glb_wr_addr = clr_cnt[SET_AW-1:0];
      sel_wr_addr = clr_cnt[SEL_AW-1:0];
      loc_wr_data = '0;
      glb_wr_data = '0;
      sel_wr_data = tfp_pkg::CTR_ZERO;
    end else if (exec_fire && (op_q == tfp_pkg::OP_UPDATE)) begin
      sel_wr_en = 1'b1;
      loc_wr_en = !use_global;
      glb_wr_en = use_global;
    end
  end

  // ---------------- table memories ----------------
  tfp_ram #(.DEPTH(SETS), .WIDTH(ROW_W)) u_loc_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (loc_idx),
    .rd_data (loc_rd),
    .wr_en   (loc_wr_en),
    .wr_addr (loc_wr_addr),
    .wr_data (loc_wr_data)
  );

  tfp_ram #(.DEPTH(SETS), .WIDTH(ROW_W)) u_glb_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (glb_idx),
    .rd_data (glb_rd),
    .wr_en   (glb_wr_en),
    .wr_addr (glb_wr_addr),
    .wr_data (glb_wr_data)
  );

  tfp_ram #(.DEPTH(SELECTOR_ENTRIES), .WIDTH(tfp_pkg::CTR_W)) u_sel_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (sel_idx),
    .rd_data (sel_rd),
    .wr_en   (sel_wr_en),
    .wr_addr (sel_wr_addr),
    .wr_data (sel_wr_data)
  );

  // ---------------- response register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire && (op_q == tfp_pkg::OP_PREDICT)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && (op_q == tfp_pkg::OP_PREDICT)) begin
      hit                <= result.hit;
      fuse_predicted     <= result.fuse;
      predicted_distance <= result.distance;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tfp_checker.sv
// ----------------------------------------------------------------------------
// tfp_checker
// port-level checks of the tournament fusion predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic                        hit,
  input wire logic                        fuse_predicted,
  input wire logic [tfp_pkg::DIST_W-1:0]  predicted_distance
);

  // a stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(fuse_predicted)
      && $stable(predicted_distance))
    else $error("response word changed while stalled");

  // fusion is only predicted from a hit
  a_fuse_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && fuse_predicted |-> hit)
    else $error("fuse predicted without hit");

  // a miss carries a zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !hit |-> predicted_distance == '0)
    else $error("miss with nonzero distance");

  // one word in flight: no acceptance right after an acceptance
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

endmodule

bind tournament_fusion_predictor tfp_checker u_tfp_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req_valid),
  .req_ready          (req_ready),
  .rsp_valid          (rsp_valid),
  .rsp_ready          (rsp_ready),
  .hit                (hit),
  .fuse_predicted     (fuse_predicted),
  .predicted_distance (predicted_distance)
);

`default_nettype wire
